// File: hdl/sbe_pkg.sv
// sbe_pkg: shared constants, register indexes and types of the sobel edge binarizer
// no dependencies; used by sobel_edge_binarize, sbe_window_cell and sbe_line_buffer
`default_nettype none

package sbe_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_SIDE   = 3;

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int CFG_WID_W  = 9;
    localparam int CFG_HGT_W  = 11;
    localparam int THR_W      = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    // internal counter widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);

    // gradient arithmetic widths
    localparam int SUM_W = PIX_W + 2;
    localparam int DIF_W = PIX_W + 1;
    localparam int GRD_W = PIX_W + 3;
    localparam int MAG_W = PIX_W + 2;

    // window columns in the cell row
    localparam int WIN_N = 3;

    localparam logic [PIX_W-1:0] EDGE_VALUE = '0;
    localparam logic [PIX_W-1:0] FLAT_VALUE = '1;

    localparam logic [CFG_WID_W-1:0] RST_IMAGE_WIDTH    = CFG_WID_W'(188);
    localparam logic [CFG_HGT_W-1:0] RST_IMAGE_HEIGHT   = CFG_HGT_W'(120);
    localparam logic [THR_W-1:0]     RST_EDGE_THRESHOLD = THR_W'(60);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } t_reg_index;

    // one column of the 3x3 window
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    // per-column sobel terms: weighted sum and vertical difference
    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        logic signed [DIF_W-1:0] diff;
    } t_terms;

    // control carried along the pipeline
    typedef struct packed {
        logic valid;
        logic emit;
        logic border;
        logic last;
    } t_ctl;

endpackage

`default_nettype wire

// File: hdl/sobel_edge_binarize.sv
// sobel_edge_binarize: streaming 3x3 sobel edge binarizer
// after the transaction that completes its window, a result passes the line store read, window
// cell, gradient and output registers; in item terms a result lags its pixel by width+1
// transactions (flush items drain the tail); throughput 1 item per cycle unless the output stalls
// synchronous active-low reset: counters, pipeline control and output valid cleared, registers
// back to defaults; line store contents are not cleared
`default_nettype none

module sobel_edge_binarize (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [sbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] pixel_gray
    input  wire logic                           s_axis_tuser,  // [0] flush
    // result output
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [7:0]                     m_axis_tdata,  // [7:0] out_value
    output logic                                m_axis_tuser,  // [0] is_border
    output logic                                m_axis_tlast
);

    localparam int PW = sbe_pkg::PIX_W;
    localparam int NC = sbe_pkg::WIN_N;

    // configuration registers
    logic [sbe_pkg::CFG_WID_W-1:0] r_width;
    logic [sbe_pkg::CFG_HGT_W-1:0] r_height;
    logic [sbe_pkg::THR_W-1:0]     r_thr;

    // position counters
    logic [sbe_pkg::COL_W-1:0] r_col,     n_col;
    logic [sbe_pkg::ROW_W-1:0] r_row,     n_row;
    logic [sbe_pkg::POS_W-1:0] r_out_pos, n_out_pos;
    logic [sbe_pkg::POS_W-1:0] r_pix_cnt, n_pix_cnt;

    logic cfg_hit;
    logic en;
    logic accept;
    logic proc;
    logic full;
    logic emit;
    logic border;
    logic last;
    logic col_zero;
    logic wrap;

    logic [sbe_pkg::WID_W-1:0]               w_eff;
    logic [sbe_pkg::WID_W-1:0]               w_last;
    logic [sbe_pkg::HGT_W-1:0]               h_eff;
    logic [sbe_pkg::HGT_W-1:0]               h_last;
    logic [sbe_pkg::WID_W+sbe_pkg::HGT_W-1:0] prod;
    logic [sbe_pkg::POS_W-1:0]               total;
    logic [sbe_pkg::ROW_W-1:0]               pr;
    logic [sbe_pkg::COL_W-1:0]               pc;
    logic [sbe_pkg::WID_W-1:0]               col_next;
    logic [PW-1:0]                           pix_in;

    // pipeline
    sbe_pkg::t_ctl r_s1;
    sbe_pkg::t_ctl r_s2;
    sbe_pkg::t_ctl r_s3;
    logic [PW-1:0] r_pix1;
    logic [PW-1:0] r_centre3;
    logic [sbe_pkg::MAG_W-1:0] r_agx3;
    logic [sbe_pkg::MAG_W-1:0] r_agy3;

    logic [PW-1:0] lb_top;
    logic [PW-1:0] lb_mid;

    sbe_pkg::t_column col_in  [NC];
    sbe_pkg::t_column col_out [NC];
    sbe_pkg::t_terms  terms   [NC];

    logic signed [sbe_pkg::GRD_W-1:0] gx;
    logic signed [sbe_pkg::GRD_W-1:0] gy;
    logic [sbe_pkg::MAG_W-1:0]        agx;
    logic [sbe_pkg::MAG_W-1:0]        agy;

    // output register
    logic          r_out_valid;
    logic [PW-1:0] r_out_data;
    logic          r_out_border;
    logic          r_out_last;

    // ---------------------------------------------------------------- config

    always_comb begin
        unique case (i_cfg_index)
            sbe_pkg::REG_IMAGE_WIDTH,
            sbe_pkg::REG_IMAGE_HEIGHT,
            sbe_pkg::REG_EDGE_THRESHOLD: cfg_hit = i_cfg_we;
            default:                     cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sbe_pkg::RST_IMAGE_WIDTH;
            r_height <= sbe_pkg::RST_IMAGE_HEIGHT;
            r_thr    <= sbe_pkg::RST_EDGE_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sbe_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[sbe_pkg::CFG_WID_W-1:0];
                end
                sbe_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[sbe_pkg::CFG_HGT_W-1:0];
                end
                sbe_pkg::REG_EDGE_THRESHOLD: begin
                    r_thr <= i_cfg_data[sbe_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if (int'(r_width) < sbe_pkg::MIN_SIDE) begin
            w_eff = sbe_pkg::WID_W'(sbe_pkg::MIN_SIDE);
        end else if (int'(r_width) > sbe_pkg::MAX_WIDTH) begin
            w_eff = sbe_pkg::WID_W'(sbe_pkg::MAX_WIDTH);
        end else begin
            w_eff = sbe_pkg::WID_W'(r_width);
        end
        if (int'(r_height) < sbe_pkg::MIN_SIDE) begin
            h_eff = sbe_pkg::HGT_W'(sbe_pkg::MIN_SIDE);
        end else if (int'(r_height) > sbe_pkg::MAX_HEIGHT) begin
            h_eff = sbe_pkg::HGT_W'(sbe_pkg::MAX_HEIGHT);
        end else begin
            h_eff = sbe_pkg::HGT_W'(r_height);
        end
    end

    assign prod   = w_eff * h_eff;
    assign total  = prod[sbe_pkg::POS_W-1:0];
    assign w_last = w_eff - 1'b1;
    assign h_last = h_eff - 1'b1;

    // ---------------------------------------------------------------- input stage

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    // past the frame end any item drains; a flush inside the frame does nothing
    assign full   = r_pix_cnt >= total;
    assign proc   = accept && (!s_axis_tuser || full);
    assign pix_in = full ? '0 : s_axis_tdata;

    assign emit     = r_pix_cnt > sbe_pkg::POS_W'(w_eff);
    assign col_zero = (r_col == '0);
    assign pr       = col_zero ? r_row - sbe_pkg::ROW_W'(2) : r_row - sbe_pkg::ROW_W'(1);
    assign pc       = col_zero ? w_last[sbe_pkg::COL_W-1:0] : r_col - 1'b1;
    assign border   = (pr == '0) || (pr == sbe_pkg::ROW_W'(h_last))
                   || (pc == '0) || (pc == w_last[sbe_pkg::COL_W-1:0]);
    assign last     = (r_out_pos == total - 1'b1);
    assign col_next = sbe_pkg::WID_W'(r_col) + 1'b1;
    assign wrap     = (col_next >= w_eff);

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_out_pos = r_out_pos;
        n_pix_cnt = r_pix_cnt;
        if (cfg_hit || (proc && emit && last)) begin
            n_col     = '0;
            n_row     = '0;
            n_out_pos = '0;
            n_pix_cnt = '0;
        end else if (proc) begin
            n_pix_cnt = r_pix_cnt + 1'b1;
            if (emit) begin
                n_out_pos = r_out_pos + 1'b1;
            end
            if (wrap) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = col_next[sbe_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_out_pos <= '0;
            r_pix_cnt <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_out_pos <= n_out_pos;
            r_pix_cnt <= n_pix_cnt;
        end
    end

    sbe_line_buffer u_line_buffer (
        .i_clk   (i_clk),
        .i_rd_en (proc),
        .i_addr  (r_col),
        .i_pixel (pix_in),
        .i_wb_en (en && r_s1.valid),
        .o_top   (lb_top),
        .o_mid   (lb_mid)
    );

    // ---------------------------------------------------------------- pipeline control

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (en) begin
            r_s1 <= '{valid: proc, emit: emit, border: border, last: last};
            r_s2 <= '{valid: r_s1.valid && r_s1.emit, emit: r_s1.emit,
                      border: r_s1.border, last: r_s1.last};
            r_s3 <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_pix1 <= pix_in;
        end
    end

    // ---------------------------------------------------------------- window cell row
    // cell 0 holds the newest (right) column, the last cell the oldest (left)

    assign col_in[0] = '{top: lb_top, mid: lb_mid, bot: r_pix1};

    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        if (gi > 0) begin : g_link
            assign col_in[gi] = col_out[gi-1];
        end
        sbe_window_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (en && r_s1.valid),
            .i_col   (col_in[gi]),
            .o_col   (col_out[gi]),
            .o_terms (terms[gi])
        );
    end

    // ---------------------------------------------------------------- gradients

    assign gx = $signed(sbe_pkg::GRD_W'(terms[0].sum)) - $signed(sbe_pkg::GRD_W'(terms[NC-1].sum));
    assign gy = sbe_pkg::GRD_W'($signed(terms[NC-1].diff))
              + (sbe_pkg::GRD_W'($signed(terms[1].diff)) <<< 1)
              + sbe_pkg::GRD_W'($signed(terms[0].diff));

    assign agx = gx[sbe_pkg::GRD_W-1] ? sbe_pkg::MAG_W'(-gx) : sbe_pkg::MAG_W'(gx);
    assign agy = gy[sbe_pkg::GRD_W-1] ? sbe_pkg::MAG_W'(-gy) : sbe_pkg::MAG_W'(gy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_agx3    <= agx;
            r_agy3    <= agy;
            r_centre3 <= col_out[1].mid;
        end
    end

    // ---------------------------------------------------------------- output register

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s3.border) begin
                r_out_data <= r_centre3;
            end else if ((r_agx3 > r_thr) || (r_agy3 > r_thr)) begin
                r_out_data <= sbe_pkg::EDGE_VALUE;
            end else begin
                r_out_data <= sbe_pkg::FLAT_VALUE;
            end
            r_out_border <= r_s3.border;
            r_out_last   <= r_s3.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_border;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: hdl/sbe_window_cell.sv
// sbe_window_cell: one column of the 3x3 window, shifted on to its neighbor
// depends on sbe_pkg (t_column, t_terms)
`default_nettype none

module sbe_window_cell (
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  sbe_pkg::t_column      i_col,
    output sbe_pkg::t_column      o_col,
    output sbe_pkg::t_terms       o_terms
);

    sbe_pkg::t_column r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // top + 2*mid + bottom, and bottom - top
    assign o_terms.sum = sbe_pkg::SUM_W'(r_col.top)
                       + (sbe_pkg::SUM_W'(r_col.mid) << 1)
                       + sbe_pkg::SUM_W'(r_col.bot);
    assign o_terms.diff = $signed(sbe_pkg::DIF_W'(r_col.bot))
                        - $signed(sbe_pkg::DIF_W'(r_col.top));

endmodule

`default_nettype wire

// File: hdl/sbe_line_buffer.sv
// sbe_line_buffer: the two previous rows, one memory per row, read data registered
// depends on sbe_pkg (widths, MAX_WIDTH)
`default_nettype none

module sbe_line_buffer (
    input  wire logic                      i_clk,
    input  wire logic                      i_rd_en,
    input  wire logic [sbe_pkg::COL_W-1:0] i_addr,
    input  wire logic [sbe_pkg::PIX_W-1:0] i_pixel,
    input  wire logic                      i_wb_en,
    output logic      [sbe_pkg::PIX_W-1:0] o_top,
    output logic      [sbe_pkg::PIX_W-1:0] o_mid
);

    logic [sbe_pkg::PIX_W-1:0] r_mid_mem [sbe_pkg::MAX_WIDTH];
    logic [sbe_pkg::PIX_W-1:0] r_top_mem [sbe_pkg::MAX_WIDTH];
    logic [sbe_pkg::PIX_W-1:0] r_top;
    logic [sbe_pkg::PIX_W-1:0] r_mid;
    logic [sbe_pkg::COL_W-1:0] r_addr;

    // middle row: read old value and write the new pixel at the same column
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid            <= r_mid_mem[i_addr];
            r_mid_mem[i_addr] <= i_pixel;
            r_addr           <= i_addr;
        end
    end

    // top row: the middle value read for the last accepted pixel moves up one row
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_top <= r_top_mem[i_addr];
        end
        if (i_wb_en) begin
            r_top_mem[r_addr] <= r_mid;
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

`default_nettype wire

// File: hdl/sbe_checker.sv
// sbe_checker: port-level assertions for sobel_edge_binarize, bound to the top level
// depends on sobel_edge_binarize port list
`default_nettype none

module sbe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tready,
    input wire logic       i_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] i_m_tdata,
    input wire logic       i_m_tuser,
    input wire logic       i_m_tlast
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("result changed while stalled");

    // interior pixels are binarized
    a_interior_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> (i_m_tdata == 8'd0) || (i_m_tdata == 8'd255))
        else $error("interior result not binary");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // input is open whenever the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input blocked with empty output");

endmodule

bind sobel_edge_binarize sbe_checker u_sbe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);

`default_nettype wire
